// File: rtl/core/utf8v_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_pkg: shared types and constants for the UTF-8 stream validator
// Byte classes, the classified word that runs from front to back, and the
// code point range check applied when a sequence completes.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  // Default queue depths (front-to-back and result queues)
  localparam int unsigned InQueueDepthDef  = 2;
  localparam int unsigned OutQueueDepthDef = 2;

  localparam int unsigned CpWidth = 21;

  // Lower bounds for each sequence length, surrogate window, top of range
  localparam logic [CpWidth-1:0] CpMin2    = 21'h00080;
  localparam logic [CpWidth-1:0] CpMin3    = 21'h00800;
  localparam logic [CpWidth-1:0] CpMin4    = 21'h10000;
  localparam logic [CpWidth-1:0] CpSurrLo  = 21'h0D800;
  localparam logic [CpWidth-1:0] CpSurrHi  = 21'h0DFFF;
  localparam logic [CpWidth-1:0] CpMax     = 21'h10FFFF;

  // Sequence length codes (length minus one)
  localparam logic [1:0] SeqLen2 = 2'd1;
  localparam logic [1:0] SeqLen3 = 2'd2;

  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_CONT,
    KIND_BAD
  } kind_e;

  // Classified word passed through the front-to-back queue
  typedef struct packed {
    logic       is_end;
    kind_e      kind;
    logic [5:0] bits;
  } utf8v_item_t;

  // Range check of a completed code point
  function automatic logic codepoint_ok(input logic [1:0] len_code,
                                        input logic [CpWidth-1:0] cp);
    logic ok;
    if (len_code == SeqLen2) begin
      ok = (cp >= CpMin2);
    end else if (len_code == SeqLen3) begin
      ok = (cp >= CpMin3) && !((cp >= CpSurrLo) && (cp <= CpSurrHi));
    end else begin
      ok = (cp >= CpMin4) && (cp <= CpMax);
    end
    return ok;
  endfunction

endpackage

// File: rtl/core/utf8v_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_queue: small register queue
// First-in first-out buffer with full/empty flags; push and pop may occur
// in the same cycle. Head word is shown combinationally.
// ----------------------------------------------------------------------------
module utf8v_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push_ok, pop_ok;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_ok, pop_ok})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/utf8v_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_front: byte intake and classification
// Sorts each incoming byte into its UTF-8 class, strips the marker bits and
// queues the classified word for the back end.
// ----------------------------------------------------------------------------
module utf8v_front import utf8v_pkg::*; #(
  parameter int unsigned InQueueDepth = InQueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  output logic        full,
  output utf8v_item_t item_o,
  output logic        item_valid_o,
  input  logic        item_pop_i
);

  utf8v_item_t                    cls;
  logic [$bits(utf8v_item_t)-1:0] head;
  logic                           q_empty;

  // Classify the byte by its leading bits
  always_comb begin
    cls.is_end = op_i;
    cls.kind   = KIND_ASCII;
    cls.bits   = '0;
    if (!op_i) begin
      if (!data_byte_i[7]) begin
        cls.kind = KIND_ASCII;
      end else if (data_byte_i[7:6] == 2'b10) begin
        cls.kind = KIND_CONT;
        cls.bits = data_byte_i[5:0];
      end else if (data_byte_i[7:5] == 3'b110) begin
        cls.kind = KIND_LEAD2;
        cls.bits = {1'b0, data_byte_i[4:0]};
      end else if (data_byte_i[7:4] == 4'b1110) begin
        cls.kind = KIND_LEAD3;
        cls.bits = {2'b00, data_byte_i[3:0]};
      end else if (data_byte_i[7:3] == 5'b11110) begin
        cls.kind = KIND_LEAD4;
        cls.bits = {3'b000, data_byte_i[2:0]};
      end else begin
        cls.kind = KIND_BAD;
      end
    end
  end

  // Decoupling queue toward the back end
  utf8v_queue #(
    .Width($bits(utf8v_item_t)),
    .Depth(InQueueDepth)
  ) u_in_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cls),
    .full_o (full),
    .pop_i  (item_pop_i),
    .data_o (head),
    .empty_o(q_empty)
  );

  assign item_o       = utf8v_item_t'(head);
  assign item_valid_o = !q_empty;

endmodule

// File: rtl/core/utf8v_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_back: sequence tracking and verdict
// Walks classified words through the sequence state, builds code points,
// keeps the sticky error and queues one verdict per end marker.
// ----------------------------------------------------------------------------
module utf8v_back import utf8v_pkg::*; #(
  parameter int unsigned OutQueueDepth = OutQueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  utf8v_item_t item_i,
  input  logic        item_valid_i,
  output logic        item_pop_o,
  input  logic        pop,
  output logic        empty,
  output logic        string_valid_o
);

  logic [1:0]         pending_q, pending_d;
  logic [1:0]         seq_len_q, seq_len_d;
  logic [CpWidth-1:0] cp_q, cp_d;
  logic               err_q, err_d;
  logic [CpWidth-1:0] cp_next;
  logic               res_full;
  logic               res_push;
  logic               verdict;

  // An end marker waits only for room in the result queue
  assign item_pop_o = item_valid_i && (!item_i.is_end || !res_full);
  assign res_push   = item_pop_o && item_i.is_end;
  assign verdict    = !err_q && (pending_q == '0);
  assign cp_next    = {cp_q[CpWidth-7:0], item_i.bits};

  // Sequence state update
  always_comb begin
    pending_d = pending_q;
    seq_len_d = seq_len_q;
    cp_d      = cp_q;
    err_d     = err_q;
    if (item_pop_o) begin
      if (item_i.is_end) begin
        pending_d = '0;
        seq_len_d = '0;
        cp_d      = '0;
        err_d     = 1'b0;
      end else if (!err_q) begin
        if (pending_q == '0) begin
          // expecting a lead byte
          case (item_i.kind)
            KIND_ASCII: ;
            KIND_LEAD2: begin
              pending_d = 2'd1;
              seq_len_d = 2'd1;
              cp_d      = CpWidth'(item_i.bits);
            end
            KIND_LEAD3: begin
              pending_d = 2'd2;
              seq_len_d = 2'd2;
              cp_d      = CpWidth'(item_i.bits);
            end
            KIND_LEAD4: begin
              pending_d = 2'd3;
              seq_len_d = 2'd3;
              cp_d      = CpWidth'(item_i.bits);
            end
            default: err_d = 1'b1;
          endcase
        end else if (item_i.kind != KIND_CONT) begin
          err_d = 1'b1;
        end else begin
          pending_d = pending_q - 2'd1;
          cp_d      = cp_next;
          if (pending_q == 2'd1) begin
            // last continuation: check the finished code point
            if (!codepoint_ok(seq_len_q, cp_next)) begin
              err_d = 1'b1;
            end
            seq_len_d = '0;
            cp_d      = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      seq_len_q <= '0;
      cp_q      <= '0;
      err_q     <= 1'b0;
    end else begin
      pending_q <= pending_d;
      seq_len_q <= seq_len_d;
      cp_q      <= cp_d;
      err_q     <= err_d;
    end
  end

  // Verdict queue toward the consumer
  utf8v_queue #(
    .Width(1),
    .Depth(OutQueueDepth)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (verdict),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (string_valid_o),
    .empty_o(empty)
  );

endmodule

// File: rtl/core/utf8_stream_validator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_validator_unit: strict UTF-8 checker, one byte per clock while full is low
//
//   Channel  Direction  Handshake          Fields
//   input    in         push / full        op_i, data_byte_i
//   result   out        empty / pop        string_valid_o
//
// One word per clock is sustained while the result queue has room; the state
// update in the back end sets that figure. A verdict passes through the input
// queue, then the result queue, and shows on the result ports once nothing
// waits ahead of it and the result queue has room.
// Reset clears both queues and the sequence state; no clearing pass.
// If the result queue fills, the back end holds at the next end marker, the
// input queue fills behind it and full rises. Data words never wait on pop.
// ----------------------------------------------------------------------------
module utf8_stream_validator_unit import utf8v_pkg::*; #(
  parameter int unsigned InQueueDepth  = InQueueDepthDef,
  parameter int unsigned OutQueueDepth = OutQueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       op_i,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic       string_valid_o
);

  utf8v_item_t item;
  logic        item_valid;
  logic        item_pop;

  // Front end: intake and classification
  utf8v_front #(
    .InQueueDepth(InQueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .full        (full),
    .item_o      (item),
    .item_valid_o(item_valid),
    .item_pop_i  (item_pop)
  );

  // Back end: sequence tracking and verdicts
  utf8v_back #(
    .OutQueueDepth(OutQueueDepth)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item),
    .item_valid_i  (item_valid),
    .item_pop_o    (item_pop),
    .pop           (pop),
    .empty         (empty),
    .string_valid_o(string_valid_o)
  );

  // The back end never takes a word that is not there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_valid)
    else $error("back end popped an empty queue");

  // Only an end marker may hold up the back end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid && !item_pop) |-> item.is_end)
    else $error("data word stalled in back end");

  // A taken end marker always leaves a verdict behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_pop && item.is_end) |=> !empty)
    else $error("verdict missing after end marker");

  // Nothing to show right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> empty)
    else $error("result queue not empty after reset");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for utf8_stream_validator_unit
// Streams strings of bytes, each closed by an end marker, into the validator.
// A built-in predictor works out each string verdict, and the result process
// compares every popped verdict with the oldest one waiting. Directed strings
// cover the error kinds. Random strings follow, mostly well formed and some
// damaged, with random idle gaps on both sides and one stretch without gaps.
// ----------------------------------------------------------------------------
module testbench;
  import utf8v_pkg::*;

  // Word opcodes
  localparam logic OpData = 1'b0;
  localparam logic OpEnd  = 1'b1;

  // Length code of a 4-byte sequence (the package names the shorter ones)
  localparam logic [1:0] SeqLen4 = 2'd3;

  localparam int unsigned MaxReports = 10;

  // Ways a random string gets damaged
  typedef enum int unsigned {
    DMG_OVERLONG,
    DMG_SURROGATE,
    DMG_TOO_BIG,
    DMG_BAD_LEAD,
    DMG_NO_CONT,
    DMG_TRUNCATE,
    DMG_NOISE,
    DMG_COUNT
  } damage_e;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic       op_i;
  logic [7:0] data_byte_i;
  logic       empty;
  logic       pop;
  logic       string_valid_o;

  // Predicted sequence state
  logic [1:0]  pend_cnt;
  logic [1:0]  seq_code;
  logic [20:0] cp_acc;
  logic        err_flag;

  bit verdicts_due[$];

  bit no_idle;
  int n_words;
  int n_strings;
  int n_checked;
  int n_valid;
  int n_mismatches;

  utf8_stream_validator_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .op_i           (op_i),
    .data_byte_i    (data_byte_i),
    .empty          (empty),
    .pop            (pop),
    .string_valid_o (string_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic kind_e classify_byte(input logic [7:0] b);
    if (!b[7]) return KIND_ASCII;
    if (b[7:6] == 2'b10) return KIND_CONT;
    if (b[7:5] == 3'b110) return KIND_LEAD2;
    if (b[7:4] == 4'b1110) return KIND_LEAD3;
    if (b[7:3] == 5'b11110) return KIND_LEAD4;
    return KIND_BAD;
  endfunction

  // Overlong, surrogate and top-of-range check on a finished sequence
  function automatic bit cp_legal(input logic [1:0] len_code, input logic [20:0] cp);
    if (len_code == SeqLen2) return cp >= CpMin2;
    if (len_code == SeqLen3) return cp >= CpMin3 && (cp < CpSurrLo || cp > CpSurrHi);
    return cp >= CpMin4 && cp <= CpMax;
  endfunction

  task automatic utf8_track_byte(input logic [7:0] b);
    kind_e k;
    k = classify_byte(b);
    if (err_flag) return;
    if (pend_cnt == 2'd0) begin
      case (k)
        KIND_ASCII: ;
        KIND_LEAD2: begin
          pend_cnt = 2'd1;
          seq_code = SeqLen2;
          cp_acc   = {16'd0, b[4:0]};
        end
        KIND_LEAD3: begin
          pend_cnt = 2'd2;
          seq_code = SeqLen3;
          cp_acc   = {17'd0, b[3:0]};
        end
        KIND_LEAD4: begin
          pend_cnt = 2'd3;
          seq_code = SeqLen4;
          cp_acc   = {18'd0, b[2:0]};
        end
        default: err_flag = 1'b1;
      endcase
    end else if (k != KIND_CONT) begin
      err_flag = 1'b1;
    end else begin
      cp_acc   = {cp_acc[14:0], b[5:0]};
      pend_cnt = pend_cnt - 2'd1;
      if (pend_cnt == 2'd0) begin
        if (!cp_legal(seq_code, cp_acc)) err_flag = 1'b1;
        seq_code = 2'd0;
        cp_acc   = '0;
      end
    end
  endtask

  // Verdict on the end marker; the string state starts over
  function automatic bit utf8_close_string();
    bit ok;
    ok       = !err_flag && pend_cnt == 2'd0;
    pend_cnt = 2'd0;
    seq_code = 2'd0;
    cp_acc   = '0;
    err_flag = 1'b0;
    return ok;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic note_error(input string msg);
    n_mismatches++;
    if (n_mismatches <= MaxReports) $display("MISMATCH: %s", msg);
  endtask

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random pop stalls, compare each popped verdict
  initial begin
    int stall_left;
    bit want;
    stall_left = 0;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        n_checked++;
        if (verdicts_due.size() == 0) begin
          note_error($sformatf("verdict %0d popped with no string pending", string_valid_o));
        end else begin
          want = verdicts_due.pop_front();
          if (string_valid_o !== want)
            note_error($sformatf("verdict %0d: expected %0d, got %0b",
                                 n_checked, want, string_valid_o));
          else if (want) n_valid++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // One word through the push side; the predictor runs at the accepting edge
  task automatic send_word(input logic op, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    op_i        <= op;
    data_byte_i <= b;
    do begin
      @(posedge clk_i);
    end while (full);
    n_words++;
    if (op == OpEnd) begin
      verdicts_due.push_back(utf8_close_string());
      n_strings++;
    end else begin
      utf8_track_byte(b);
    end
  endtask

  task automatic end_string();
    send_word(OpEnd, 8'($urandom_range(0, 255)));
  endtask

  // Sends the low n bytes of w, most significant first
  task automatic send_seq(input int n, input logic [31:0] w);
    for (int i = n - 1; i >= 0; i--) send_word(OpData, w[8*i +: 8]);
  endtask

  function automatic logic [31:0] encode_cp(input int len, input logic [20:0] cp);
    case (len)
      1:       return {25'd0, cp[6:0]};
      2:       return {16'd0, 3'b110, cp[10:6], 2'b10, cp[5:0]};
      3:       return {8'd0, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
      default: return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                       2'b10, cp[5:0]};
    endcase
  endfunction

  // First nbytes of the len-byte form of cp
  task automatic send_codepoint(input int len, input logic [20:0] cp, input int nbytes);
    send_seq(nbytes, encode_cp(len, cp) >> (8 * (len - nbytes)));
  endtask

  // Legal code point for a length, leaning on the range edges
  function automatic logic [20:0] legal_cp(input int len);
    int r;
    r = $urandom_range(0, 7);
    case (len)
      1: return 21'($urandom_range(0, 'h7F));
      2: begin
        if (r == 0) return CpMin2;
        if (r == 1) return 21'h7FF;
        return 21'($urandom_range('h80, 'h7FF));
      end
      3: begin
        case (r)
          0:       return CpMin3;
          1:       return 21'hD7FF;
          2:       return 21'hE000;
          3:       return 21'hFFFF;
          4, 5:    return 21'($urandom_range('h800, 'hD7FF));
          default: return 21'($urandom_range('hE000, 'hFFFF));
        endcase
      end
      default: begin
        if (r == 0) return CpMin4;
        if (r == 1) return CpMax;
        return 21'($urandom_range('h10000, 'h10FFFF));
      end
    endcase
  endfunction

  task automatic send_damage(input damage_e dmg);
    int len;
    logic [7:0] b;
    len = $urandom_range(2, 4);
    case (dmg)
      DMG_OVERLONG: begin
        if (len == 2) send_codepoint(len, 21'($urandom_range(0, 'h7F)), len);
        else if (len == 3) send_codepoint(len, 21'($urandom_range(0, 'h7FF)), len);
        else send_codepoint(len, 21'($urandom_range(0, 'hFFFF)), len);
      end
      DMG_SURROGATE: send_codepoint(3, 21'($urandom_range('hD800, 'hDFFF)), 3);
      DMG_TOO_BIG:   send_codepoint(4, 21'($urandom_range('h110000, 'h1FFFFF)), 4);
      DMG_BAD_LEAD: begin
        if ($urandom_range(0, 1)) b = 8'($urandom_range('h80, 'hBF));
        else b = 8'($urandom_range('hF8, 'hFF));
        send_word(OpData, b);
      end
      DMG_NO_CONT: begin
        send_codepoint(len, legal_cp(len), $urandom_range(1, len - 1));
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        send_word(OpData, b);
      end
      DMG_TRUNCATE: send_codepoint(len, legal_cp(len), $urandom_range(1, len - 1));
      default: repeat ($urandom_range(1, 6)) send_word(OpData, 8'($urandom_range(0, 255)));
    endcase
  endtask

  // A random string: well-formed units, sometimes one damaged spot
  task automatic send_random_string();
    int units;
    int bad_pos;
    int len;
    bit damaged;
    damage_e dmg;
    units   = $urandom_range(0, 6);
    damaged = ($urandom_range(0, 3) == 0);
    dmg     = damage_e'($urandom_range(0, DMG_COUNT - 1));
    bad_pos = (dmg == DMG_TRUNCATE) ? units : $urandom_range(0, units);
    for (int i = 0; i <= units; i++) begin
      if (damaged && i == bad_pos) send_damage(dmg);
      if (i < units) begin
        len = $urandom_range(1, 4);
        send_codepoint(len, legal_cp(len), len);
      end
    end
    end_string();
  endtask

  // Push side goes quiet until every verdict has been popped
  task automatic wait_drained();
    push <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_valid_extremes();
    end_string();                 // empty string
    send_seq(1, 32'h00);
    send_seq(4, 32'hF48FBFBF);    // U+10FFFF
    end_string();
  endtask

  task automatic test_bad_lead();
    send_seq(1, 32'h80);          // continuation with no lead
    end_string();
    send_seq(2, 32'hFF41);        // byte above 0xF7, then a byte after the error
    end_string();
  endtask

  task automatic test_missing_continuation();
    send_seq(2, 32'hC241);
    end_string();
  endtask

  task automatic test_truncation();
    send_seq(2, 32'hE282);
    end_string();
  endtask

  task automatic test_range_errors();
    send_seq(3, 32'hEDA080);      // surrogate
    end_string();
    send_seq(4, 32'hF4908080);    // above U+10FFFF
    end_string();
  endtask

  task automatic test_random_strings(input int word_target);
    int cnt;
    cnt = 0;
    while (n_words < word_target) begin
      send_random_string();
      cnt++;
      if (cnt % 25 == 0) wait_drained();
    end
  endtask

  task automatic test_back_to_back(input int word_target);
    no_idle = 1'b1;
    while (n_words < word_target) send_random_string();
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    op_i        <= OpData;
    data_byte_i <= 8'h00;
    no_idle      = 1'b0;
    n_words      = 0;
    n_strings    = 0;
    n_checked    = 0;
    n_valid      = 0;
    n_mismatches = 0;
    pend_cnt     = 2'd0;
    seq_code     = 2'd0;
    cp_acc       = '0;
    err_flag     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_valid_extremes();
    test_bad_lead();
    test_missing_continuation();
    test_truncation();
    test_range_errors();
    wait_drained();
    test_random_strings(560);
    test_back_to_back(650);

    push <= 1'b0;
    for (int k = 0; k < 4000 && verdicts_due.size() != 0; k++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (verdicts_due.size() != 0)
      note_error($sformatf("%0d verdicts never arrived", verdicts_due.size()));

    $display("sent %0d words in %0d strings, checked %0d verdicts (%0d valid)",
             n_words, n_strings, n_checked, n_valid);
    $display("covered bad leads, missing and truncated sequences, overlong, surrogate, %s",
             "out-of-range code points, random stalls and a gap-free stretch");
    if (n_mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: utf8_stream_validator_unit.f
rtl/core/utf8v_pkg.sv
rtl/core/utf8v_queue.sv
rtl/core/utf8v_front.sv
rtl/core/utf8v_back.sv
rtl/core/utf8_stream_validator_unit.sv
tb/sv/testbench.sv
